// ----- hw/rtl/bwlp_pkg.sv -----
// shared types and constants for the butterworth low-pass biquad
// no dependencies
package bwlp_pkg;

  localparam int RATE_W   = 18;
  localparam int CUT_W    = 17;
  localparam int SMP_W    = 16;
  localparam int COEF_W   = 32;
  localparam int WIDE_W   = 64;
  localparam int QUOT_W   = 33;
  localparam int XSUM_W   = 18;
  localparam int ACC_W    = 52;
  localparam int CNT_W    = 6;

  localparam logic [RATE_W-1:0] RATE_RESET  = 18'd48000;
  localparam logic [13:0]       PI_Q12      = 14'd12868;
  localparam logic [14:0]       SQRT2PI_Q12 = 15'd18198;
  localparam logic [CNT_W-1:0]  DIV_LAST    = 6'd33;

  localparam logic REG_SAMPLE_RATE = 1'b0;

  typedef struct packed {
    logic [RATE_W-1:0]       fs;
    logic [CUT_W-1:0]        fc;
    logic signed [SMP_W-1:0] x;
  } item_t;

  typedef struct packed {
    logic load;
    logic step;
    logic first;
  } div_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROD,
    S_SQ,
    S_SUM,
    S_DIV,
    S_COEF,
    S_MUL,
    S_ACC,
    S_OUT
  } state_t;

endpackage

// ----- hw/rtl/butterworth_lowpass_biquad.sv -----
// top level of the butterworth low-pass biquad: config register, front, queue, back
// depends on bwlp_pkg, bwlp_front, bwlp_queue, bwlp_back
//
// usage
//   input channel: in_valid/in_ready with sample_in (Q1.15) and cutoff_hz; one beat
//   per sample. output channel: out_valid/out_ready with sample_out (Q1.15).
//   apb port: sample_rate at address 0, reset 48000; write only while idle.
// processing
//   a beat enters a two-entry queue at acceptance; the back end then takes one sample
//   at a time through a fetch state, the coefficient product, square and sum states,
//   the bit-serial coefficient dividers (one quotient bit per cycle),
//   then coefficient rounding, multiply, accumulate and output rounding.
//   the queue takes new beats while the back end works on a sample, until it is full.
// reset
//   clears the filter history, the queue and the output valid flag, and loads
//   the default sample rate
// stalls
//   when out_ready is low the result holds in the output register; the back
//   end finishes the next sample and waits; the queue then fills and in_ready
//   drops
module butterworth_lowpass_biquad (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [bwlp_pkg::SMP_W-1:0] sample_in,
  input  logic [bwlp_pkg::CUT_W-1:0]        cutoff_hz,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bwlp_pkg::SMP_W-1:0] sample_out,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [bwlp_pkg::RATE_W-1:0] sample_rate;
  logic            q_full, q_empty, push, pop;
  bwlp_pkg::item_t item_in, item_out;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= bwlp_pkg::RATE_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == bwlp_pkg::REG_SAMPLE_RATE) begin
      sample_rate <= pwdata[bwlp_pkg::RATE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == bwlp_pkg::REG_SAMPLE_RATE) ? 32'(sample_rate) : 32'd0;

  bwlp_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample_in   (sample_in),
    .cutoff_hz   (cutoff_hz),
    .sample_rate (sample_rate),
    .q_full      (q_full),
    .push        (push),
    .item        (item_in)
  );

  bwlp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item_in  (item_in),
    .full     (q_full),
    .pop      (pop),
    .item_out (item_out),
    .empty    (q_empty)
  );

  bwlp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .head       (item_out),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out)
  );

endmodule

// ----- hw/rtl/bwlp_front.sv -----
// front end: takes input beats, clamps the cutoff and forms a queue entry
// depends on bwlp_pkg
module bwlp_front (
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [bwlp_pkg::SMP_W-1:0]   sample_in,
  input  logic [bwlp_pkg::CUT_W-1:0]          cutoff_hz,
  input  logic [bwlp_pkg::RATE_W-1:0]         sample_rate,
  input  logic                                q_full,
  output logic                                push,
  output bwlp_pkg::item_t                     item
);

  logic [bwlp_pkg::CUT_W-1:0] half_rate;
  logic [bwlp_pkg::CUT_W-1:0] fc_clip;

  always_comb begin
    half_rate = sample_rate[bwlp_pkg::RATE_W-1:1];
    fc_clip   = (cutoff_hz > half_rate) ? half_rate : cutoff_hz;
    if (fc_clip == '0) begin
      fc_clip = 17'd1;
    end
  end

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;
  assign item.fs  = sample_rate;
  assign item.fc  = fc_clip;
  assign item.x   = sample_in;

endmodule

// ----- hw/rtl/bwlp_queue.sv -----
// two-entry queue between front and back
// depends on bwlp_pkg
module bwlp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bwlp_pkg::item_t item_in,
  output logic            full,
  input  logic            pop,
  output bwlp_pkg::item_t item_out,
  output logic            empty
);

  bwlp_pkg::item_t mem [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  assign item_out = mem[rd_ptr];
  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);

endmodule

// ----- hw/rtl/bwlp_div.sv -----
// restoring divider, one quotient bit per step, for coefficient ratios
// depends on bwlp_pkg
module bwlp_div (
  input  logic                             clk,
  input  bwlp_pkg::div_ctrl_t              ctrl,
  input  logic [bwlp_pkg::WIDE_W-1:0]      num,
  input  logic [bwlp_pkg::WIDE_W-1:0]      den,
  output logic [bwlp_pkg::QUOT_W-1:0]      quot
);

  logic [bwlp_pkg::WIDE_W-1:0] rem;
  logic [bwlp_pkg::WIDE_W-1:0] rem_sh;
  logic                        fits;

  always_comb begin
    rem_sh = ctrl.first ? rem : {rem[bwlp_pkg::WIDE_W-2:0], 1'b0};
    fits   = (rem_sh >= den);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem  <= num;
      quot <= '0;
    end else if (ctrl.step) begin
      rem  <= fits ? rem_sh - den : rem_sh;
      quot <= {quot[bwlp_pkg::QUOT_W-2:0], fits};
    end
  end

endmodule

// ----- hw/rtl/bwlp_back.sv -----
// back end: coefficient derivation, biquad recursion, history and output register
// depends on bwlp_pkg and bwlp_div
module bwlp_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  input  bwlp_pkg::item_t                   head,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bwlp_pkg::SMP_W-1:0] sample_out
);

  bwlp_pkg::state_t    state;
  bwlp_pkg::state_t    state_next;
  bwlp_pkg::div_ctrl_t dctl;
  logic [bwlp_pkg::CNT_W-1:0] cnt;
  logic out_load;

  bwlp_pkg::item_t cur;
  logic [29:0] u;
  logic [30:0] v;
  logic [31:0] w;
  logic [bwlp_pkg::WIDE_W-1:0] sq_a, sq_b, sq_c, den;
  logic [bwlp_pkg::WIDE_W-1:0] num_b, num_a1, num_a2;
  logic a1_neg;
  logic signed [bwlp_pkg::XSUM_W-1:0] xsum;
  logic [bwlp_pkg::QUOT_W-1:0] q_b, q_a1, q_a2;
  logic signed [bwlp_pkg::COEF_W-1:0] coef_b, coef_a1, coef_a2;
  logic signed [49:0] prod_b;
  logic signed [63:0] prod_1, prod_2;
  logic signed [bwlp_pkg::ACC_W-1:0] acc;
  logic signed [bwlp_pkg::SMP_W-1:0] prev_in_1, prev_in_2;
  logic signed [31:0] prev_out_1, prev_out_2;

  logic [32:0] a1_mag;
  logic [31:0] b_mag;
  logic [31:0] a2_mag;
  logic signed [bwlp_pkg::ACC_W-1:0] y_full;
  logic signed [31:0] y_sat;
  logic signed [33:0] o_full;
  logic signed [bwlp_pkg::SMP_W-1:0] o_sat;

  bwlp_div u_div_b  (.clk(clk), .ctrl(dctl), .num(num_b),  .den(den), .quot(q_b));
  bwlp_div u_div_a1 (.clk(clk), .ctrl(dctl), .num(num_a1), .den(den), .quot(q_a1));
  bwlp_div u_div_a2 (.clk(clk), .ctrl(dctl), .num(num_a2), .den(den), .quot(q_a2));

  always_comb begin
    state_next = state;
    unique case (state)
      bwlp_pkg::S_IDLE: if (!q_empty) state_next = bwlp_pkg::S_PROD;
      bwlp_pkg::S_PROD: state_next = bwlp_pkg::S_SQ;
      bwlp_pkg::S_SQ:   state_next = bwlp_pkg::S_SUM;
      bwlp_pkg::S_SUM:  state_next = bwlp_pkg::S_DIV;
      bwlp_pkg::S_DIV:  if (cnt == bwlp_pkg::DIV_LAST) state_next = bwlp_pkg::S_COEF;
      bwlp_pkg::S_COEF: state_next = bwlp_pkg::S_MUL;
      bwlp_pkg::S_MUL:  state_next = bwlp_pkg::S_ACC;
      bwlp_pkg::S_ACC:  state_next = bwlp_pkg::S_OUT;
      bwlp_pkg::S_OUT:  if (!out_valid || out_ready) state_next = bwlp_pkg::S_IDLE;
      default:          state_next = bwlp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pop        = (state == bwlp_pkg::S_IDLE) && !q_empty;
    dctl.load  = (state == bwlp_pkg::S_DIV) && (cnt == '0);
    dctl.step  = (state == bwlp_pkg::S_DIV) && (cnt != '0);
    dctl.first = (cnt == 6'd1);
    out_load   = (state == bwlp_pkg::S_OUT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bwlp_pkg::S_IDLE;
      cnt        <= '0;
      out_valid  <= 1'b0;
      prev_in_1  <= '0;
      prev_in_2  <= '0;
      prev_out_1 <= '0;
      prev_out_2 <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state == bwlp_pkg::S_DIV && cnt != bwlp_pkg::DIV_LAST) ? cnt + 6'd1 : '0;
      if (out_load) begin
        out_valid  <= 1'b1;
        prev_in_2  <= prev_in_1;
        prev_in_1  <= cur.x;
        prev_out_2 <= prev_out_1;
        prev_out_1 <= y_sat;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // coefficient rounding and output rounding
  always_comb begin
    a1_mag = 33'((34'(q_a1) + 34'd1) >> 1);
    b_mag  = 32'((33'(q_b[32:1]) + 33'd1) >> 1);
    a2_mag = 32'((33'(q_a2[32:1]) + 33'd1) >> 1);
    y_full = (acc + 52'sd16384) >>> 15;
    if (y_full > 52'sh0_0000_7FFF_FFFF) begin
      y_sat = 32'sh7FFF_FFFF;
    end else if (y_full < -52'sh0_0000_8000_0000) begin
      y_sat = -32'sh8000_0000;
    end else begin
      y_sat = y_full[31:0];
    end
    o_full = (34'(y_sat) + 34'sd16384) >>> 15;
    if (o_full > 34'sd32767) begin
      o_sat = 16'sh7FFF;
    end else if (o_full < -34'sd32768) begin
      o_sat = -16'sh8000;
    end else begin
      o_sat = o_full[15:0];
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      bwlp_pkg::S_IDLE: begin
        if (!q_empty) cur <= head;
      end
      bwlp_pkg::S_PROD: begin
        u <= {cur.fs, 12'd0};
        v <= 31'(cur.fc * bwlp_pkg::PI_Q12);
        w <= 32'(cur.fc * bwlp_pkg::SQRT2PI_Q12);
      end
      bwlp_pkg::S_SQ: begin
        sq_a <= 64'(u * u);
        sq_b <= 64'(u * w);
        sq_c <= 64'(v * v);
      end
      bwlp_pkg::S_SUM: begin
        den    <= sq_a + sq_b + sq_c;
        num_b  <= sq_c;
        a1_neg <= (sq_a < sq_c);
        num_a1 <= (sq_a >= sq_c) ? sq_a - sq_c : sq_c - sq_a;
        num_a2 <= sq_a + sq_c - sq_b;
        xsum   <= 18'(cur.x) + (18'(prev_in_1) <<< 1) + 18'(prev_in_2);
      end
      bwlp_pkg::S_DIV: begin
      end
      bwlp_pkg::S_COEF: begin
        coef_b  <= {1'b0, b_mag[30:0]};
        coef_a2 <= 32'd0 - {1'b0, a2_mag[30:0]};
        if (a1_neg) begin
          coef_a1 <= 32'd0 - a1_mag[31:0];
        end else if (a1_mag[32] || a1_mag[31]) begin
          coef_a1 <= 32'sh7FFF_FFFF;
        end else begin
          coef_a1 <= a1_mag[31:0];
        end
      end
      bwlp_pkg::S_MUL: begin
        prod_b <= 50'(coef_b * xsum);
        prod_1 <= coef_a1 * prev_out_1;
        prod_2 <= coef_a2 * prev_out_2;
      end
      bwlp_pkg::S_ACC: begin
        acc <= 52'(prod_b) + 52'(prod_1 >>> 15) + 52'(prod_2 >>> 15);
      end
      bwlp_pkg::S_OUT: begin
        if (out_load) sample_out <= o_sat;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- dv/tb_top.sv -----
// self-checking testbench for butterworth_lowpass_biquad: random and directed samples
// with cutoff sweeps, apb rate changes and handshake stalls, checked by a scoreboard
// depends on bwlp_pkg and the butterworth_lowpass_biquad rtl
`timescale 1ns / 1ps

class biquad_scoreboard;
  logic signed [15:0] exp_q[$];
  longint unsigned rate;
  longint in1, in2, out1, out2;
  int errors;
  int shown;

  function new();
    rate = 48000;
    in1 = 0;
    in2 = 0;
    out1 = 0;
    out2 = 0;
    errors = 0;
    shown = 0;
  endfunction

  function longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // round(num * 2^bits / den), half up
  function longint div_round(longint unsigned num, longint unsigned den, int bits);
    longint unsigned q, r;
    q = num / den;
    r = num % den;
    for (int i = 0; i <= bits; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    return longint'((q + 64'd1) >> 1);
  endfunction

  function void note_sample(logic signed [15:0] x, logic [16:0] cut);
    longint unsigned fs, fc, u, v, w, a, bw, c, d;
    longint lim, cb, a1, a2, xs, acc, y, o;
    lim = 64'sd1 <<< 31;
    fs = rate;
    fc = cut;
    if (fc > (fs >> 1)) fc = fs >> 1;
    if (fc < 1) fc = 1;
    u = fs * 4096;
    v = fc * longint'(bwlp_pkg::PI_Q12);
    w = fc * longint'(bwlp_pkg::SQRT2PI_Q12);
    a = u * u;
    bw = u * w;
    c = v * v;
    d = a + bw + c;
    cb = clamp(div_round(c, d, 30), -lim, lim - 1);
    if (a >= c) a1 = div_round(a - c, d, 31);
    else a1 = -div_round(c - a, d, 31);
    a1 = clamp(a1, -lim, lim - 1);
    a2 = clamp(-div_round((a + c) - bw, d, 30), -lim, lim - 1);
    xs = longint'(x) + 2 * in1 + in2;
    acc = cb * xs + ((a1 * out1) >>> 15) + ((a2 * out2) >>> 15);
    y = clamp((acc + 64'sd16384) >>> 15, -lim, lim - 1);
    o = clamp((y + 64'sd16384) >>> 15, -32768, 32767);
    exp_q.push_back(o[15:0]);
    in2 = in1;
    in1 = x;
    out2 = out1;
    out1 = y;
  endfunction

  function void flag(string what, longint e, longint g);
    errors++;
    if (shown < 10) begin
      shown++;
      $display("%s: expected %0d got %0d", what, e, g);
    end
  endfunction

  function void check_sample(logic signed [15:0] got);
    logic signed [15:0] e;
    if (exp_q.size() == 0) begin
      flag("unexpected sample_out", 0, got);
      return;
    end
    e = exp_q.pop_front();
    if (got !== e) flag("sample_out", e, got);
  endfunction
endclass

module tb_top;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] sample_in = '0;
  logic [16:0] cutoff_hz = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] sample_out;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  biquad_scoreboard sb = new();
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  localparam logic [2:0] ADDR_RATE = 3'd0;
  localparam logic [2:0] ADDR_NONE = 3'd4;

  butterworth_lowpass_biquad u_dut (.*);

  always #10 clk = ~clk;

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // call at a rising edge; returns after the beat is taken and any random gap
  task automatic send_sample(logic signed [15:0] x, logic [16:0] cut);
    bit rdy;
    in_valid <= 1'b1;
    sample_in <= x;
    cutoff_hz <= cut;
    do begin
      @(negedge clk);
      rdy = in_ready;
      if (rdy) sb.note_sample(x, cut);
      @(posedge clk);
    end while (!rdy);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic apb_access(logic wr, logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (!wr && addr == ADDR_RATE && prdata[17:0] !== sb.rate[17:0])
      sb.flag("prdata", sb.rate, prdata);
    @(posedge clk);
    if (wr && addr == ADDR_RATE) sb.rate = data[17:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.exp_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_run(int n);
    int len, cmode, smode;
    logic [16:0] cut;
    logic signed [15:0] x;
    while (n > 0) begin
      len = $urandom_range(4, 24);
      cmode = $urandom_range(0, 3);
      smode = $urandom_range(0, 3);
      case (cmode)
        0: cut = 17'($urandom_range(0, 131071));
        1: cut = 17'($urandom_range(1, 2000));
        2: cut = 17'((sb.rate >> 1) + $urandom_range(0, 4) - 2);
        default: cut = 17'($urandom_range(100, 20000));
      endcase
      for (int i = 0; i < len && n > 0; i++, n--) begin
        case (smode)
          0: x = 16'($urandom);
          1: x = (i % 2) ? 16'sh7fff : 16'sh8000;
          2: x = (i / 4 % 2) ? 16'sh7fff : 16'sh8000;
          default: x = $signed(16'($urandom_range(0, 255))) - 16'sd128;
        endcase
        if ($urandom_range(0, 15) == 0) cut = 17'($urandom);
        send_sample(x, cut);
      end
    end
  endtask

  // receiver
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        hold_req = 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
        if (!quiet) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 19) - 1) @(posedge clk);
        end
      end
    end
  end

  always @(negedge clk)
    if (!rst && out_valid && out_ready) sb.check_sample(sample_out);

  initial begin
    logic [31:0] rates[7];
    rates = '{32'd48000, 32'd0, 32'd1, 32'd8000, 32'd192000, 32'd262143, 32'd44100};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_access(1'b0, ADDR_RATE, '0);
    send_sample(16'sh7fff, 17'd0);
    send_sample(16'sh7fff, 17'd1);
    send_sample(16'sh8000, 17'd24000);
    send_sample(16'sh8000, 17'd24001);
    send_sample(16'sh7fff, 17'd96000);
    send_sample(16'sh8000, 17'd131071);
    send_sample(16'sh0000, 17'd24000);
    for (int i = 0; i < 12; i++)
      send_sample(i[0] ? 16'sh7fff : 16'sh8000, 17'd23999);
    send_sample(16'sh0001, 17'd1000);
    drain();
    for (int p = 0; p < 7; p++) begin
      apb_access(1'b1, ADDR_NONE, 32'hffff_ffff);
      apb_access(1'b1, ADDR_RATE, rates[p]);
      apb_access(1'b0, ADDR_RATE, '0);
      @(posedge clk);
      if (p == 3) hold_req = 1'b1;
      if (p == 6) quiet = 1'b1;
      random_run(p < 3 ? 60 : 120);
      drain();
    end
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ----- filelist.f -----
hw/rtl/bwlp_pkg.sv
hw/rtl/bwlp_front.sv
hw/rtl/bwlp_queue.sv
hw/rtl/bwlp_div.sv
hw/rtl/bwlp_back.sv
hw/rtl/butterworth_lowpass_biquad.sv
dv/tb_top.sv
